// ===== rtl/core/efeg_pkg.sv =====
// Shared types and constants for the eased fade envelope generator.
// No dependencies; used by eased_fade_envelope_generator_top.
package efeg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 32;

  localparam int LVL_W  = FRAC_BITS + 1;           // Q1.16 level
  localparam int SCL_W  = FRAC_BITS + 3;           // Q3.16 ring scale
  localparam int DUR_W  = 16;
  localparam int PROD_W = SCL_W + LVL_W;
  localparam int CFG_W  = SCL_W;                   // widest register

  localparam logic [LVL_W-1:0] ONE_FX = LVL_W'(1) << FRAC_BITS;

  // request codes
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_SHOW  = 2'd1;
  localparam logic [1:0] REQ_HIDE  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // register indexes
  localparam logic CFG_DURATION = 1'b0;
  localparam logic CFG_SCALE    = 1'b1;

  typedef enum logic [1:0] {
    PH_HIDDEN    = 2'd0,
    PH_APPEAR    = 2'd1,
    PH_VISIBLE   = 2'd2,
    PH_DISAPPEAR = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [LVL_W-1:0] dim_level;
    logic [LVL_W-1:0] focus_level;
    logic [SCL_W-1:0] ring_scale;
    logic [LVL_W-1:0] ring_opacity;
    logic             surface_on;
    logic             more_frames;
    logic [1:0]       phase_now;
  } out_t;

endpackage

// ===== rtl/core/eased_fade_envelope_generator_top.sv =====
// Eased fade envelope generator: sequencer, shared divider step and shared multiplier.
// Depends on efeg_pkg (types, codes, fixed-point constants).
//
// One transaction at a time: in_stall is low only while the block is idle. Show, reset
// and hide from the visible phase finish in the accept cycle. Frame queries while hidden
// or visible produce a result in the cycle after accept. A query during a transition, or a
// hide while appearing, runs elapsed-time subtract, a duration compare, 16 restoring-divide
// steps (one quotient bit per cycle on a 17-bit subtractor) and two to four passes through
// the single 19x17 multiplier; a request at or before the start time skips the compare and
// the divide. Appearing results form in S_MB, disappearing ones in S_MC; a hide returns
// to idle from S_EASE. A transition that has already run its course skips the divide and
// multiplies. The block takes the next transaction once the result has been taken.
module eased_fade_envelope_generator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  efeg_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output efeg_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [efeg_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int LW = efeg_pkg::LVL_W;
  localparam int SW = efeg_pkg::SCL_W;
  localparam int TW = efeg_pkg::TIME_BITS;
  localparam int DW = efeg_pkg::DUR_W;
  localparam int PW = efeg_pkg::PROD_W;
  localparam int FB = efeg_pkg::FRAC_BITS;
  localparam int CW = $clog2(FB);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ELAP = 11'b000_0000_0010,
    S_CHK  = 11'b000_0000_0100,
    S_DIV  = 11'b000_0000_1000,
    S_SQ   = 11'b000_0001_0000,
    S_CUBE = 11'b000_0010_0000,
    S_EASE = 11'b000_0100_0000,
    S_MA   = 11'b000_1000_0000,
    S_MB   = 11'b001_0000_0000,
    S_MC   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  efeg_pkg::phase_t  phase_r, phase_nxt;
  logic [TW-1:0]     start_r, start_nxt;
  logic [LW-1:0]     fdim_r, fdim_nxt;
  logic [LW-1:0]     ffocus_r, ffocus_nxt;
  logic [DW-1:0]     dur_r;
  logic [SW-1:0]     fscale_r;

  logic [1:0]        req_r, req_nxt;
  logic [TW-1:0]     now_r, now_nxt;
  logic [TW-1:0]     elap_r, elap_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [FB-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     rest_r, rest_nxt;     // 1 - p
  logic [LW-1:0]     r3_r, r3_nxt;         // (1 - p)^3
  logic [LW-1:0]     eased_r, eased_nxt;
  logic [LW-1:0]     dim_r, dim_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  efeg_pkg::out_t    out_r, out_nxt;

  // datapath helpers
  logic [TW:0]       diff;
  logic              not_after;
  logic [DW:0]       rem_sh;
  logic              qbit;
  logic [DW:0]       rem_sub;
  logic [FB-1:0]     quo_step;
  logic [SW-1:0]     mul_a;
  logic [LW-1:0]     mul_b;
  logic [LW-1:0]     prod_lvl;
  logic [SW-1:0]     prod_scl;
  logic              scale_up;
  logic [SW-1:0]     scale_diff;
  logic [SW-1:0]     one_scl;

  function automatic efeg_pkg::out_t visible_frame(input logic [SW-1:0] scale);
    efeg_pkg::out_t f;
    f.dim_level    = efeg_pkg::ONE_FX;
    f.focus_level  = efeg_pkg::ONE_FX;
    f.ring_scale   = scale;
    f.ring_opacity = '0;
    f.surface_on   = 1'b1;
    f.more_frames  = 1'b0;
    f.phase_now    = efeg_pkg::PH_VISIBLE;
    return f;
  endfunction

  assign one_scl    = SW'(efeg_pkg::ONE_FX);
  assign scale_up   = (fscale_r >= one_scl);
  assign scale_diff = scale_up ? (fscale_r - one_scl) : (one_scl - fscale_r);

  assign diff      = {1'b0, now_r} - {1'b0, start_r};
  assign not_after = diff[TW] | (diff[TW-1:0] == '0);

  assign rem_sh   = {rem_r, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, dur_r};
  assign qbit     = (rem_sh >= {1'b0, dur_r});
  assign quo_step = {quo_r[FB-2:0], qbit};

  assign prod_lvl = prod_r[FB +: LW];
  assign prod_scl = prod_r[FB +: SW];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = SW'(rest_r);
        mul_b = rest_r;
      end
      S_CUBE: begin
        mul_a = SW'(prod_lvl);
        mul_b = rest_r;
      end
      S_MA: begin
        if (phase_r == efeg_pkg::PH_APPEAR) begin
          mul_a = scale_diff;
          mul_b = eased_r;
        end else begin
          mul_a = SW'(fdim_r);
          mul_b = r3_r;
        end
      end
      S_MB: begin
        mul_a = SW'(ffocus_r);
        mul_b = r3_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    start_nxt  = start_r;
    fdim_nxt   = fdim_r;
    ffocus_nxt = ffocus_r;
    req_nxt    = req_r;
    now_nxt    = now_r;
    elap_nxt   = elap_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    rest_nxt   = rest_r;
    r3_nxt     = r3_r;
    eased_nxt  = eased_r;
    dim_nxt    = dim_r;
    out_nxt    = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data.req_type;
          now_nxt = in_data.now_ms;
          unique case (in_data.req_type)
            efeg_pkg::REQ_SHOW: begin
              phase_nxt  = efeg_pkg::PH_APPEAR;
              start_nxt  = in_data.now_ms;
              fdim_nxt   = efeg_pkg::ONE_FX;
              ffocus_nxt = efeg_pkg::ONE_FX;
            end
            efeg_pkg::REQ_RESET: begin
              phase_nxt  = efeg_pkg::PH_HIDDEN;
              start_nxt  = '0;
              fdim_nxt   = efeg_pkg::ONE_FX;
              ffocus_nxt = efeg_pkg::ONE_FX;
            end
            efeg_pkg::REQ_HIDE: begin
              if (phase_r == efeg_pkg::PH_VISIBLE) begin
                phase_nxt  = efeg_pkg::PH_DISAPPEAR;
                start_nxt  = in_data.now_ms;
                fdim_nxt   = efeg_pkg::ONE_FX;
                ffocus_nxt = efeg_pkg::ONE_FX;
              end else if (phase_r == efeg_pkg::PH_APPEAR) begin
                state_nxt = S_ELAP;
              end
            end
            efeg_pkg::REQ_FRAME: begin
              if (phase_r == efeg_pkg::PH_HIDDEN) begin
                out_nxt   = '0;
                state_nxt = S_OUT;
              end else if (phase_r == efeg_pkg::PH_VISIBLE) begin
                out_nxt   = visible_frame(fscale_r);
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_ELAP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ELAP: begin
        if (not_after) begin
          rest_nxt  = efeg_pkg::ONE_FX;
          state_nxt = S_SQ;
        end else begin
          elap_nxt  = diff[TW-1:0];
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        if (elap_r >= TW'(dur_r)) begin
          // transition has run its course
          if (phase_r == efeg_pkg::PH_APPEAR) begin
            if (req_r == efeg_pkg::REQ_HIDE) begin
              phase_nxt  = efeg_pkg::PH_DISAPPEAR;
              start_nxt  = now_r;
              fdim_nxt   = efeg_pkg::ONE_FX;
              ffocus_nxt = efeg_pkg::ONE_FX;
              state_nxt  = S_IDLE;
            end else begin
              phase_nxt = efeg_pkg::PH_VISIBLE;
              out_nxt   = visible_frame(fscale_r);
              state_nxt = S_OUT;
            end
          end else begin
            phase_nxt  = efeg_pkg::PH_HIDDEN;
            start_nxt  = '0;
            fdim_nxt   = efeg_pkg::ONE_FX;
            ffocus_nxt = efeg_pkg::ONE_FX;
            out_nxt    = '0;
            state_nxt  = S_OUT;
          end
        end else begin
          rem_nxt   = elap_r[DW-1:0];
          quo_nxt   = '0;
          cnt_nxt   = CW'(FB - 1);
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rest_nxt  = efeg_pkg::ONE_FX - LW'(quo_step);
          state_nxt = S_SQ;
        end
      end

      S_SQ:   state_nxt = S_CUBE;
      S_CUBE: state_nxt = S_EASE;

      S_EASE: begin
        r3_nxt    = prod_lvl;
        eased_nxt = efeg_pkg::ONE_FX - prod_lvl;
        if (phase_r == efeg_pkg::PH_APPEAR && req_r == efeg_pkg::REQ_HIDE) begin
          phase_nxt  = efeg_pkg::PH_DISAPPEAR;
          start_nxt  = now_r;
          fdim_nxt   = efeg_pkg::ONE_FX - prod_lvl;
          ffocus_nxt = efeg_pkg::ONE_FX - prod_lvl;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_MA;
        end
      end

      S_MA: state_nxt = S_MB;

      S_MB: begin
        if (phase_r == efeg_pkg::PH_APPEAR) begin
          out_nxt.dim_level    = eased_r;
          out_nxt.focus_level  = eased_r;
          out_nxt.ring_scale   = scale_up ? (one_scl + prod_scl) : (one_scl - prod_scl);
          out_nxt.ring_opacity = r3_r;
          out_nxt.surface_on   = 1'b1;
          out_nxt.more_frames  = 1'b1;
          out_nxt.phase_now    = efeg_pkg::PH_APPEAR;
          state_nxt            = S_OUT;
        end else begin
          dim_nxt   = prod_lvl;
          state_nxt = S_MC;
        end
      end

      S_MC: begin
        out_nxt.dim_level    = dim_r;
        out_nxt.focus_level  = prod_lvl;
        out_nxt.ring_scale   = fscale_r;
        out_nxt.ring_opacity = '0;
        out_nxt.surface_on   = 1'b1;
        out_nxt.more_frames  = 1'b1;
        out_nxt.phase_now    = efeg_pkg::PH_DISAPPEAR;
        state_nxt            = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= efeg_pkg::PH_HIDDEN;
      start_r  <= '0;
      fdim_r   <= efeg_pkg::ONE_FX;
      ffocus_r <= efeg_pkg::ONE_FX;
      dur_r    <= DW'(200);
      fscale_r <= SW'(98304);
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      start_r  <= start_nxt;
      fdim_r   <= fdim_nxt;
      ffocus_r <= ffocus_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          efeg_pkg::CFG_DURATION: dur_r    <= cfg_wdata[DW-1:0];
          efeg_pkg::CFG_SCALE:    fscale_r <= cfg_wdata[SW-1:0];
          default:                dur_r    <= dur_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    now_r   <= now_nxt;
    elap_r  <= elap_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    rest_r  <= rest_nxt;
    r3_r    <= r3_nxt;
    eased_r <= eased_nxt;
    dim_r   <= dim_nxt;
    prod_r  <= prod_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // never take a new transaction while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // divider remainder stays below the duration
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dur_r))
    else $error("divider remainder out of range");

  // hidden frames carry no levels
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.phase_now == efeg_pkg::PH_HIDDEN) |->
      (out_data.dim_level == '0 && out_data.focus_level == '0 &&
       out_data.ring_scale == '0 && !out_data.surface_on))
    else $error("hidden frame not blank");

  // transitions always request more frames
  a_more_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.phase_now == efeg_pkg::PH_APPEAR ||
                   out_data.phase_now == efeg_pkg::PH_DISAPPEAR)) |->
      (out_data.more_frames && out_data.surface_on))
    else $error("transition frame without more_frames");
`endif

endmodule
